@@ hw/rtl/cts_pkg.sv @@
// ----------------------------------------------------------------------------
// Countdown thread scheduler package
// Shared types and constants for the slot chain and its controller.
// ----------------------------------------------------------------------------
package cts_pkg;

   // default number of thread slots
   localparam int SLOTS_DEF = 16;

   // fixed field widths
   localparam int PRIO_W    = 8;
   localparam int OUT_IDX_W = 4;
   localparam int KIND_W    = 2;
   localparam int REQ_DW    = 8;
   localparam int RSP_DW    = 16;

   // request kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_TICK   = 2'd0,
      KIND_CREATE = 2'd1,
      KIND_TERM   = 2'd2,
      KIND_START  = 2'd3
   } kind_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_WALK = 2'd1,
      ST_DONE = 2'd2
   } state_type;

   // contents of one thread slot
   typedef struct packed {
      logic              used;
      logic [PRIO_W-1:0] reload;
      logic [PRIO_W-1:0] count;
   } slot_type;

   // broadcast operation applied to the resting chain
   typedef struct packed {
      logic              clear_all;   // drop every used flag
      logic              load_idle;   // with clear_all: slot 0 becomes the idle thread
      logic              clear_sel;   // drop used flag of the selected slot
      logic              reload_sel;  // reload counter of the selected slot
      logic [PRIO_W-1:0] idle_prio;
   } cell_op_type;

endpackage

@@ hw/rtl/cts_cell.sv @@
// ----------------------------------------------------------------------------
// Slot cell
// Holds one thread slot. While the chain shifts it takes its neighbor's
// slot; at rest it applies the broadcast operation addressed to its index.
// ----------------------------------------------------------------------------
module cts_cell #(
   parameter int INDEX = 0,
   parameter int IDX_W = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift_en,
   input  cts_pkg::slot_type    shift_in,
   input  cts_pkg::cell_op_type op,
   input  logic [IDX_W-1:0]     sel_idx,
   output cts_pkg::slot_type    slot_q
);
   import cts_pkg::*;

   slot_type slot_ff;
   slot_type slot_in;
   logic     hit;

   assign hit = (sel_idx == IDX_W'(INDEX));

   // next slot value
   always_comb begin
      slot_in = slot_ff;
      if (shift_en) begin
         slot_in = shift_in;
      end else if (op.clear_all) begin
         slot_in.used = 1'b0;
         if ((INDEX == 0) && op.load_idle) begin
            slot_in.used   = 1'b1;
            slot_in.reload = op.idle_prio;
            slot_in.count  = op.idle_prio;
         end
      end else if (op.clear_sel && hit) begin
         slot_in.used = 1'b0;
      end else if (op.reload_sel && hit) begin
         slot_in.count = slot_ff.reload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign slot_q = slot_ff;

endmodule

@@ hw/rtl/cts_ctrl.sv @@
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences the slot chain: walks it for tick and create, broadcasts
// terminate, start and reload, and holds the result register.
// ----------------------------------------------------------------------------
module cts_ctrl #(
   parameter int SLOTS = cts_pkg::SLOTS_DEF,
   parameter int IDX_W = $clog2(SLOTS)
) (
   input  logic                         clock,
   input  logic                         reset,
   // request side
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [cts_pkg::KIND_W-1:0]   req_kind,
   input  logic [cts_pkg::PRIO_W-1:0]   req_prio,
   // result side
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [cts_pkg::RSP_DW-1:0]   rsp_tdata,
   // configuration
   input  logic                         csr_we,
   input  logic [cts_pkg::PRIO_W-1:0]   csr_wdata,
   // chain
   input  cts_pkg::slot_type            head_slot,
   output cts_pkg::slot_type            tail_slot,
   output logic                         shift_en,
   output cts_pkg::cell_op_type         cell_op,
   output logic [IDX_W-1:0]             sel_idx
);
   import cts_pkg::*;

   localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(SLOTS - 1);

   state_type           state_ff, state_in;
   kind_type            kind_ff, kind_in;
   logic [PRIO_W-1:0]   prio_ff, prio_in;
   logic [IDX_W-1:0]    step_ff, step_in;
   logic [IDX_W-1:0]    best_ff, best_in;
   logic [PRIO_W-1:0]   best_cnt_ff, best_cnt_in;
   logic                found_ff, found_in;
   logic [IDX_W-1:0]    slot_ff, slot_in;
   logic [IDX_W-1:0]    cur_ff, cur_in;
   logic                none_ff, none_in;
   logic [PRIO_W-1:0]   idle_prio_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DW-1:0]   rsp_data_ff, rsp_data_in;

   logic [PRIO_W-1:0]      head_dec;
   logic [IDX_W-1:0]       rsp_cur;
   logic                   rsp_vld;
   logic [IDX_W+3:0]       cur_ext;
   logic [IDX_W+3:0]       slot_ext;
   logic [OUT_IDX_W-1:0]   out_cur;
   logic [OUT_IDX_W-1:0]   out_slot;
   logic                   out_fail;

   // decremented head counter, saturating at zero
   assign head_dec = head_slot.count - PRIO_W'(head_slot.count != '0);

   // result fields
   assign rsp_cur  = (kind_ff == KIND_TICK) ? best_ff : cur_ff;
   assign rsp_vld  = (kind_ff == KIND_TICK) ? 1'b1 : !none_ff;
   assign cur_ext  = {4'b0000, rsp_cur};
   assign slot_ext = {4'b0000, slot_ff};
   assign out_cur  = rsp_vld ? cur_ext[OUT_IDX_W-1:0] : '0;
   assign out_fail = (kind_ff == KIND_CREATE) && !found_ff;
   assign out_slot = ((kind_ff == KIND_CREATE) && found_ff) ? slot_ext[OUT_IDX_W-1:0] : '0;

   // next state and chain control
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      prio_in      = prio_ff;
      step_in      = step_ff;
      best_in      = best_ff;
      best_cnt_in  = best_cnt_ff;
      found_in     = found_ff;
      slot_in      = slot_ff;
      cur_in       = cur_ff;
      none_in      = none_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;
      shift_en     = 1'b0;
      cell_op      = '0;
      sel_idx      = cur_ff;
      tail_slot    = head_slot;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               kind_in  = kind_type'(req_kind);
               prio_in  = req_prio;
               step_in  = '0;
               found_in = 1'b0;
               slot_in  = '0;
               unique case (kind_type'(req_kind))
                  KIND_TICK: begin
                     none_in  = 1'b0;
                     state_in = ST_WALK;
                  end
                  KIND_CREATE: begin
                     state_in = ST_WALK;
                  end
                  KIND_TERM: begin
                     cell_op.clear_sel = !none_ff;
                     state_in          = ST_DONE;
                  end
                  KIND_START: begin
                     cell_op.clear_all = 1'b1;
                     cell_op.load_idle = 1'b1;
                     cell_op.idle_prio = idle_prio_ff;
                     none_in           = 1'b1;
                     cur_in            = '0;
                     state_in          = ST_DONE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_WALK: begin
            // one slot passes the head per cycle
            shift_en = 1'b1;
            step_in  = step_ff + 1'b1;
            if (kind_ff == KIND_TICK) begin
               tail_slot.count = head_dec;
               if (step_ff == '0) begin
                  best_in     = '0;
                  best_cnt_in = head_dec;
               end else if (head_slot.used && (head_slot.count < best_cnt_ff)) begin
                  best_in     = step_ff;
                  best_cnt_in = head_dec;
               end
            end else if (!found_ff && !head_slot.used) begin
               tail_slot.used   = 1'b1;
               tail_slot.reload = prio_ff;
               tail_slot.count  = prio_ff;
               found_in         = 1'b1;
               slot_in          = step_ff;
            end
            if (step_ff == LAST_STEP) begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            // reload of the chosen slot repeats harmlessly while stalled
            if (kind_ff == KIND_TICK) begin
               cell_op.reload_sel = 1'b1;
               sel_idx            = best_ff;
            end
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(RSP_DW - 2 - 2 * OUT_IDX_W){1'b0}},
                               rsp_vld, out_cur, out_fail, out_slot};
               if (kind_ff == KIND_TICK) begin
                  cur_in = best_ff;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= '0;
         none_ff      <= 1'b1;
         idle_prio_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         none_ff      <= none_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            idle_prio_ff <= csr_wdata;
         end
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      prio_ff     <= prio_in;
      step_ff     <= step_in;
      best_ff     <= best_in;
      best_cnt_ff <= best_cnt_in;
      found_ff    <= found_in;
      slot_ff     <= slot_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ hw/rtl/countdown_thread_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// Countdown thread scheduler
// Deadline-counter priority scheduler over a ring of thread slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one transfer per request. req_tuser[1:0] is the kind
//   (tick, create, terminate, start), req_tdata[7:0] the priority used
//   by create. rsp channel: exactly one result per request, packed in
//   rsp_tdata. csr_we / csr_wdata write the idle thread priority; write
//   it only while no request is in flight.
//   Tick and create walk the slot ring one slot per cycle. One request is
//   worked on at a time; the next request is taken as soon as the
//   controller is back in idle.
//   The result sits in an output register: a stalled receiver does not
//   stop the next request from being walked, only its result waits until
//   the previous one has been transferred.
//   Reset clears all slots, the idle priority and the current thread
//   (no thread current); no result is pending after reset.
// ----------------------------------------------------------------------------
module countdown_thread_scheduler_top #(
   parameter int SLOTS = cts_pkg::SLOTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // request: tdata[7:0] priority_req
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [cts_pkg::REQ_DW-1:0]  req_tdata,
   // request: tuser[1:0] kind
   input  logic [cts_pkg::KIND_W-1:0]  req_tuser,
   // result: tdata[3:0] created_slot, [4] create_failed,
   //         [8:5] current_thread, [9] current_valid, [15:10] zero
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [cts_pkg::RSP_DW-1:0]  rsp_tdata,
   // configuration: idle_priority
   input  logic                        csr_we,
   input  logic [cts_pkg::PRIO_W-1:0]  csr_wdata
);
   import cts_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);

   slot_type          slot_q [SLOTS];
   slot_type          tail_slot;
   logic              shift_en;
   cell_op_type       cell_op;
   logic [IDX_W-1:0]  sel_idx;

   // controller
   cts_ctrl #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .req_prio   (req_tdata[PRIO_W-1:0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .head_slot  (slot_q[0]),
      .tail_slot  (tail_slot),
      .shift_en   (shift_en),
      .cell_op    (cell_op),
      .sel_idx    (sel_idx)
   );

   // slot ring: each cell takes its upper neighbor, the last takes the head
   for (genvar k = 0; k < SLOTS; k++) begin : g_cell
      slot_type shift_in;
      if (k == SLOTS - 1) begin : g_tail
         assign shift_in = tail_slot;
      end else begin : g_mid
         assign shift_in = slot_q[k+1];
      end
      cts_cell #(
         .INDEX (k),
         .IDX_W (IDX_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .shift_in (shift_in),
         .op       (cell_op),
         .sel_idx  (sel_idx),
         .slot_q   (slot_q[k])
      );
   end

endmodule

@@ hw/rtl/cts_checker.sv @@
// ----------------------------------------------------------------------------
// Scheduler port checker
// Port-level properties of the scheduler results, bound to the top level.
// ----------------------------------------------------------------------------
module cts_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [cts_pkg::RSP_DW-1:0]  rsp_tdata
);
   import cts_pkg::*;

   // no result pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

   // failed create reports slot zero
   a_fail_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[4]) |-> (rsp_tdata[3:0] == 4'd0))
      else $error("failed create with nonzero slot");

   // no current thread reports index zero
   a_none_idx: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[9]) |-> (rsp_tdata[8:5] == 4'd0))
      else $error("invalid current thread with nonzero index");

endmodule

bind countdown_thread_scheduler_top cts_checker u_cts_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ tb/countdown_thread_scheduler_checker.sv @@
// ----------------------------------------------------------------------------
// Countdown thread scheduler checker
// Watches the request, result and configuration ports, keeps its own copy of
// the slot table, predicts one result per request transfer and compares each
// result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module cts_schedule_checker #(
   parameter int SLOTS = cts_pkg::SLOTS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [cts_pkg::REQ_DW-1:0] req_tdata,
   input  logic [cts_pkg::KIND_W-1:0] req_tuser,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [cts_pkg::RSP_DW-1:0] rsp_tdata,
   input  logic                       csr_we,
   input  logic [cts_pkg::PRIO_W-1:0] csr_wdata,
   output int                         results_owed,
   output int                         results_seen,
   output int                         mismatches
);
   import cts_pkg::*;

   // result layout, msb first
   typedef struct packed {
      logic [5:0]           pad;
      logic                 cur_valid;
      logic [OUT_IDX_W-1:0] cur_thread;
      logic                 create_failed;
      logic [OUT_IDX_W-1:0] created_slot;
   } sched_rsp_type;

   // shadow slot table
   logic              slot_busy   [SLOTS];
   logic [PRIO_W-1:0] slot_reload [SLOTS];
   logic [PRIO_W-1:0] slot_count  [SLOTS];
   int                cur_slot;
   logic              cur_none;
   logic [PRIO_W-1:0] idle_prio;

   sched_rsp_type owed_q[$];
   int            seen;
   int            errs;

   assign results_seen = seen;
   assign mismatches   = errs;

   task automatic report_mismatch(input string what, input int got_v, input int want_v);
      errs++;
      if (errs <= 40)
         $display("[%0t] result %0d: %s is %0d, expected %0d", $time, seen, what,
                  got_v, want_v);
   endtask

   // lowest free slot gets the priority as reload and counter
   task automatic claim_slot(input logic [PRIO_W-1:0] prio, output bit ok, output int slot);
      ok   = 1'b0;
      slot = 0;
      for (int i = 0; i < SLOTS; i++) begin
         if (!ok && !slot_busy[i]) begin
            slot_busy[i]   = 1'b1;
            slot_reload[i] = prio;
            slot_count[i]  = prio;
            ok             = 1'b1;
            slot           = i;
         end
      end
   endtask

   // one scheduling tick: compare against best as it stands, then decrement
   task automatic run_tick();
      int best;
      best = 0;
      if (cur_none) begin
         cur_slot = 0;
         cur_none = 1'b0;
      end
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_busy[i] && slot_count[i] < slot_count[best])
            best = i;
         if (slot_count[i] != 0)
            slot_count[i] = slot_count[i] - 1'b1;
      end
      slot_count[best] = slot_reload[best];
      cur_slot         = best;
   endtask

   task automatic schedule_request(input kind_type kind, input logic [PRIO_W-1:0] prio,
                                   output sched_rsp_type r);
      bit ok;
      int slot;
      ok   = 1'b1;
      slot = 0;
      case (kind)
         KIND_TICK: begin
            run_tick();
         end
         KIND_CREATE: begin
            claim_slot(prio, ok, slot);
            if (!ok)
               slot = 0;
         end
         KIND_TERM: begin
            if (!cur_none)
               slot_busy[cur_slot] = 1'b0;
         end
         default: begin
            // start keeps reload values and counters, drops every used flag
            for (int i = 0; i < SLOTS; i++)
               slot_busy[i] = 1'b0;
            cur_none = 1'b1;
            cur_slot = 0;
            claim_slot(idle_prio, ok, slot);
            ok   = 1'b1;
            slot = 0;
         end
      endcase
      r               = '0;
      r.created_slot  = slot[OUT_IDX_W-1:0];
      r.create_failed = !ok;
      r.cur_thread    = cur_none ? '0 : cur_slot[OUT_IDX_W-1:0];
      r.cur_valid     = !cur_none;
   endtask

   // track transfers at each edge: results first, they always belong to older requests
   always @(posedge clock) begin
      sched_rsp_type got;
      sched_rsp_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_busy[i]   = 1'b0;
            slot_reload[i] = '0;
            slot_count[i]  = '0;
         end
         cur_slot  = 0;
         cur_none  = 1'b1;
         idle_prio = '0;
         owed_q.delete();
      end else begin
         if (csr_we)
            idle_prio = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (owed_q.size() == 0) begin
               report_mismatch("rsp_tdata with nothing owed", int'(rsp_tdata), 0);
            end else begin
               want = owed_q.pop_front();
               if (got.created_slot != want.created_slot)
                  report_mismatch("created_slot", got.created_slot, want.created_slot);
               if (got.create_failed !== want.create_failed)
                  report_mismatch("create_failed", got.create_failed, want.create_failed);
               if (got.cur_thread != want.cur_thread)
                  report_mismatch("current_thread", got.cur_thread, want.cur_thread);
               if (got.cur_valid !== want.cur_valid)
                  report_mismatch("current_valid", got.cur_valid, want.cur_valid);
               if (got.pad != '0)
                  report_mismatch("padding", got.pad, 0);
            end
            seen++;
         end
         if (req_tvalid && req_tready) begin
            schedule_request(kind_type'(req_tuser), req_tdata[PRIO_W-1:0], want);
            owed_q.push_back(want);
         end
      end
      results_owed <= owed_q.size();
   end

endmodule

@@ tb/countdown_thread_scheduler_top_tb.sv @@
// ----------------------------------------------------------------------------
// Countdown thread scheduler testbench
// Drives requests and idle priority writes into the scheduler, with random
// gaps on both channels, a long result hold-off and drain pauses; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module countdown_thread_scheduler_top_tb;
   import cts_pkg::*;

   localparam int CLK_PERIOD   = 12;
   localparam int LIMIT_CYCLES = 600000;
   localparam int HOLD_CYCLES  = 250;
   localparam int PHASE_ITEMS  = 50;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_DW-1:0] req_tdata;
   logic [KIND_W-1:0] req_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_DW-1:0] rsp_tdata;
   logic              csr_we;
   logic [PRIO_W-1:0] csr_wdata;

   int results_owed;
   int results_seen;
   int mismatches;

   // stimulus knobs and counters, some shared with the receiver process
   bit req_idle_en;
   bit rsp_idle_en;
   bit hold_request;
   bit tx_up;
   int kind_seen [4];
   int cfg_writes;

   countdown_thread_scheduler_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   cts_schedule_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .results_owed (results_owed),
      .results_seen (results_seen),
      .mismatches   (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // run limit
   initial begin
      #(LIMIT_CYCLES * CLK_PERIOD);
      $display("countdown_thread_scheduler_top_tb failed");
      $finish;
   end

   // mostly no gap, some short ones, a few long ones
   function automatic int pick_gap(input bit en);
      int r;
      if (!en)
         return 0;
      r = $urandom_range(0, 19);
      if (r == 0)
         return $urandom_range(20, 60);
      if (r < 8)
         return $urandom_range(1, 4);
      return 0;
   endfunction

   // priorities lean to zero, full scale and small values so counters collide
   function automatic logic [PRIO_W-1:0] pick_prio();
      int r;
      r = $urandom_range(0, 9);
      if (r < 2)
         return '0;
      if (r == 2)
         return '1;
      if (r < 7)
         return PRIO_W'($urandom_range(1, 15));
      return PRIO_W'($urandom_range(0, 255));
   endfunction

   // result receiver: random stalls plus an on-demand long hold-off
   initial begin
      int hold_left;
      int gap_left;
      hold_left  = 0;
      gap_left   = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_tready <= 1'b0;
         end else begin
            gap_left = pick_gap(rsp_idle_en);
            rsp_tready <= (gap_left == 0);
            if (gap_left > 0)
               gap_left--;
         end
      end
   end

   task automatic stop_req();
      if (tx_up) begin
         req_tvalid <= 1'b0;
         tx_up = 1'b0;
      end
   endtask

   // one request transfer, optionally preceded by an idle gap
   task automatic send_req(input kind_type kind, input logic [PRIO_W-1:0] prio);
      int gap;
      gap = pick_gap(req_idle_en);
      if (gap > 0) begin
         stop_req();
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      tx_up = 1'b1;
      req_tuser  <= kind;
      req_tdata  <= prio;
      do @(posedge clock); while (!req_tready);
      kind_seen[int'(kind)]++;
   endtask

   task automatic wait_drained();
      stop_req();
      do @(posedge clock); while (results_owed != 0);
   endtask

   // register write only with the block idle
   task automatic write_idle_prio(input logic [PRIO_W-1:0] value);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
      cfg_writes++;
   endtask

   // random phase: well-formed start, then mixed traffic with table fills
   task automatic run_phase(input logic [PRIO_W-1:0] cfg, input bit tx_idle,
                            input bit rx_idle, input bit pressure);
      int r;
      write_idle_prio(cfg);
      req_idle_en = tx_idle;
      rsp_idle_en = rx_idle;
      send_req(KIND_START, pick_prio());
      for (int k = 0; k < PHASE_ITEMS; k++) begin
         if (k == PHASE_ITEMS / 2)
            wait_drained();
         if (pressure && k == PHASE_ITEMS / 4)
            hold_request = 1'b1;
         r = $urandom_range(0, 99);
         if (r < 4 || k == 1) begin
            // overfill the table so the last create fails
            repeat (SLOTS_DEF + 1) send_req(KIND_CREATE, pick_prio());
         end else if (r < 6) begin
            send_req(KIND_START, pick_prio());
         end else if (r < 16) begin
            send_req(KIND_TERM, pick_prio());
         end else if (r < 46) begin
            send_req(KIND_CREATE, pick_prio());
         end else begin
            send_req(KIND_TICK, pick_prio());
         end
      end
   endtask

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = KIND_TICK;
      csr_we       = 1'b0;
      csr_wdata    = '0;
      req_idle_en  = 1'b0;
      rsp_idle_en  = 1'b0;
      hold_request = 1'b0;
      tx_up        = 1'b0;
      cfg_writes   = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: no current thread, empty table, extremes of priority
      send_req(KIND_TERM,   8'h00);
      send_req(KIND_TICK,   8'h00);
      send_req(KIND_START,  8'hff);
      send_req(KIND_TERM,   8'h00);
      send_req(KIND_CREATE, 8'hff);
      send_req(KIND_CREATE, 8'h00);
      send_req(KIND_CREATE, 8'h01);
      send_req(KIND_TICK,   8'h00);
      send_req(KIND_TICK,   8'h00);
      send_req(KIND_TICK,   8'h00);
      send_req(KIND_TERM,   8'h00);
      send_req(KIND_TICK,   8'h00);
      send_req(KIND_CREATE, 8'h80);
      send_req(KIND_CREATE, 8'h7f);
      send_req(KIND_TICK,   8'h55);
      send_req(KIND_TERM,   8'haa);
      send_req(KIND_TERM,   8'h00);
      send_req(KIND_TICK,   8'h00);
      write_idle_prio(8'hff);
      send_req(KIND_START,  8'h00);
      send_req(KIND_TICK,   8'h00);
      send_req(KIND_TICK,   8'h00);

      // random phases over several idle priority settings
      run_phase(8'h00, 1'b0, 1'b0, 1'b0);
      run_phase(8'h01, 1'b1, 1'b1, 1'b1);
      run_phase(PRIO_W'($urandom_range(0, 255)), 1'b1, 1'b1, 1'b0);
      run_phase(PRIO_W'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b1);

      wait_drained();
      repeat (25) @(posedge clock);
      $display("requests sent: %0d tick, %0d create, %0d terminate, %0d start",
               kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
      $display("results compared: %0d, idle priority writes: %0d", results_seen, cfg_writes);
      if (mismatches == 0)
         $display("countdown_thread_scheduler_top_tb passed");
      else
         $display("countdown_thread_scheduler_top_tb failed");
      $finish;
   end

endmodule
